FILE: hw/rtl/sks_pkg.sv
// Shared types and constants for the sorted key set.
`timescale 1ns / 1ps
package sks_pkg;

	localparam int KEY_W        = 16;
	localparam int CAPACITY_DEF = 64;

	// Operation codes carried in the op field
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef logic [KEY_W-1:0] key_t;

	// Compare status that every cell reports to the top level and to its right neighbor
	typedef struct packed {
		logic ge;   // slot is empty or holds a key >= the probe key
		logic eq;   // slot is valid and holds the probe key
	} cell_stat_t;

endpackage

FILE: hw/rtl/sks_in_if.sv
// Input channel: valid/ready handshake carrying op and key.
`timescale 1ns / 1ps
interface sks_in_if;
	logic          valid;
	logic          ready;
	logic          op;
	sks_pkg::key_t key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface

FILE: hw/rtl/sks_out_if.sv
// Output channel: valid/ready handshake carrying the lookup/insert result.
`timescale 1ns / 1ps
interface sks_out_if;
	logic valid;
	logic ready;
	logic present;
	logic added;
	logic full_reject;

	modport source (output valid, output present, output added, output full_reject,
		input ready);
	modport sink (input valid, input present, input added, input full_reject,
		output ready);
endinterface

FILE: hw/rtl/sorted_key_set_core.sv
// Sorted, duplicate-free set of 16-bit keys held in a chain of CAPACITY cells.
// Every cell compares its key against the incoming key at once, so an insert or
// a query is decided combinationally and one transaction is taken per cycle; the
// result is loaded into an output register in the cycle after, and a new input is taken
// whenever that register is empty or being drained in the same cycle. An insert
// shifts all entries at and above its sorted position one cell to the right.
// present reports a key already held; added marks an insert that stored its key;
// full_reject marks an insert of a new key refused because CAPACITY keys are held.
// No clearing is needed after reset: the entry count alone marks which cells hold keys.
`timescale 1ns / 1ps
module sorted_key_set_core #(
	parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sks_in_if.sink    in_ch,
	sks_out_if.source out_ch
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]       count_q;
	sks_pkg::key_t       cell_key  [CAPACITY];
	sks_pkg::cell_stat_t cell_stat [CAPACITY];
	logic [CAPACITY-1:0] eq_vec;

	logic in_acc;
	logic found;
	logic is_insert;
	logic has_room;
	logic do_insert;

	logic out_valid_q;
	logic present_q;
	logic added_q;
	logic reject_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic          left_ge;
			sks_pkg::key_t left_key;
			if (gi == 0) begin : g_head
				assign left_ge  = 1'b0;
				assign left_key = in_ch.key;
			end else begin : g_body
				assign left_ge  = cell_stat[gi-1].ge;
				assign left_key = cell_key[gi-1];
			end
			sks_cell u_cell (
				.clk        (clk),
				.slot_valid (count_q > CW'(gi)),
				.probe_key  (in_ch.key),
				.shift_en   (do_insert),
				.left_key   (left_key),
				.left_ge    (left_ge),
				.key        (cell_key[gi]),
				.stat       (cell_stat[gi])
			);
			assign eq_vec[gi] = cell_stat[gi].eq;
		end
	endgenerate

	assign found     = |eq_vec;
	assign is_insert = (in_ch.op == sks_pkg::OP_INSERT);
	assign has_room  = (count_q < CW'(CAPACITY));
	assign do_insert = in_acc && is_insert && !found && has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + CW'(1);
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			present_q <= found;
			added_q   <= is_insert && !found && has_room;
			reject_q  <= is_insert && !found && !has_room;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.present     = present_q;
	assign out_ch.added       = added_q;
	assign out_ch.full_reject = reject_q;

endmodule

FILE: hw/rtl/sks_cell.sv
// One slot of the sorted chain: holds a key, compares it, shifts right on insert.
`timescale 1ns / 1ps
module sks_cell (
	input  logic                clk,
	input  logic                slot_valid,
	input  sks_pkg::key_t       probe_key,
	input  logic                shift_en,
	input  sks_pkg::key_t       left_key,
	input  logic                left_ge,
	output sks_pkg::key_t       key,
	output sks_pkg::cell_stat_t stat
);

	sks_pkg::key_t key_q;

	always_comb begin
		stat.ge = !slot_valid || (key_q >= probe_key);
		stat.eq = slot_valid && (key_q == probe_key);
	end

	// First slot at or past the insert point takes the new key, the rest take the left key
	always_ff @(posedge clk) begin
		if (shift_en && stat.ge) begin
			key_q <= left_ge ? left_key : probe_key;
		end
	end

	assign key = key_q;

endmodule

FILE: hw/rtl/sks_checker.sv
// Port-level assertions for the sorted key set, bound to the top level.
`timescale 1ns / 1ps
module sks_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic present,
	input logic added,
	input logic full_reject
);

	// Result flags are mutually exclusive
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones({present, added, full_reject}) <= 1))
		else $error("more than one result flag set");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A result only follows an accepted transaction
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without input transaction");

	// The block never stalls input while its output register is free
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

bind sorted_key_set_core sks_checker u_sks_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.present     (out_ch.present),
	.added       (out_ch.added),
	.full_reject (out_ch.full_reject)
);
